/* design/mcpi_pkg.sv */
// shared constants, types and register reset values for the motor current pi controller
`default_nettype none

package mcpi_pkg;

    // sample and gain formats
    localparam int SAMPLE_WIDTH       = 13;
    localparam int GAIN_FRACTION_BITS = 16;
    localparam int GAIN_INT_BITS      = 8;
    localparam int GAIN_WIDTH         = GAIN_INT_BITS + GAIN_FRACTION_BITS;
    localparam int DUTY_WIDTH         = 14;

    // datapath widths
    localparam int DEV_WIDTH   = SAMPLE_WIDTH + 1;
    localparam int PROD_WIDTH  = DEV_WIDTH + GAIN_WIDTH;
    localparam int ACC_WIDTH   = DUTY_WIDTH + GAIN_FRACTION_BITS + 1;
    localparam int SUM_WIDTH   = PROD_WIDTH + 2;
    localparam int DRIVE_WIDTH = SUM_WIDTH + 1;

    // configuration port
    localparam int CFG_IDX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH = GAIN_WIDTH;

    // register reset values
    localparam logic [GAIN_WIDTH-1:0] RST_FEEDFORWARD   = GAIN_WIDTH'(490000);
    localparam logic [GAIN_WIDTH-1:0] RST_PROPORTIONAL  = GAIN_WIDTH'(685960);
    localparam logic [GAIN_WIDTH-1:0] RST_INTEGRAL_STEP = GAIN_WIDTH'(686);
    localparam logic [DUTY_WIDTH-1:0] RST_INTEGRAL_LIM  = DUTY_WIDTH'(8333);
    localparam logic [DUTY_WIDTH-1:0] RST_FULL_DUTY     = DUTY_WIDTH'(10000);

    // register indexes
    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_FEEDFORWARD   = 3'd0,
        CFG_PROPORTIONAL  = 3'd1,
        CFG_INTEGRAL_STEP = 3'd2,
        CFG_INTEGRAL_LIM  = 3'd3,
        CFG_FULL_DUTY     = 3'd4
    } t_cfg_idx;

    // live register set
    typedef struct packed {
        logic [GAIN_WIDTH-1:0] feedforward_gain;
        logic [GAIN_WIDTH-1:0] proportional_gain;
        logic [GAIN_WIDTH-1:0] integral_step_gain;
        logic [DUTY_WIDTH-1:0] integral_limit;
        logic [DUTY_WIDTH-1:0] full_duty;
    } t_cfg;

    typedef logic signed [PROD_WIDTH-1:0] t_prod;
    typedef logic signed [ACC_WIDTH-1:0]  t_acc;
    typedef logic signed [SUM_WIDTH-1:0]  t_sum;

    // registered products of one request
    typedef struct packed {
        logic  enable;
        logic  clear_integral;
        t_prod int_prod;
        t_prod ff_prod;
        t_prod kp_prod;
    } t_prod_word;

    // integrator stage strobes
    typedef struct packed {
        logic load;
        logic update;
    } t_integ_ctl;

endpackage

`default_nettype wire

/* design/mcpi_in_if.sv */
// sample request channel: valid, ready and the sample fields
`default_nettype none

interface mcpi_in_if;
    logic                                     valid;
    logic                                     ready;
    logic                                     enable;
    logic                                     clear_integral;
    logic signed [mcpi_pkg::SAMPLE_WIDTH-1:0] target_counts;
    logic signed [mcpi_pkg::SAMPLE_WIDTH-1:0] measured_counts;

    modport source (
        output valid, enable, clear_integral, target_counts, measured_counts,
        input  ready
    );
    modport sink (
        input  valid, enable, clear_integral, target_counts, measured_counts,
        output ready
    );
endinterface

`default_nettype wire

/* design/mcpi_out_if.sv */
// result request channel: valid, ready and the bridge drive fields
`default_nettype none

interface mcpi_out_if;
    logic                            valid;
    logic                            ready;
    logic [mcpi_pkg::DUTY_WIDTH-1:0] duty_leg_a;
    logic [mcpi_pkg::DUTY_WIDTH-1:0] duty_leg_b;
    logic                            driver_on;
    logic                            saturated;

    modport source (
        output valid, duty_leg_a, duty_leg_b, driver_on, saturated,
        input  ready
    );
    modport sink (
        input  valid, duty_leg_a, duty_leg_b, driver_on, saturated,
        output ready
    );
endinterface

`default_nettype wire

/* design/mcpi_cfg_regs.sv */
// configuration register file for gains and limits
`default_nettype none

module mcpi_cfg_regs (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [mcpi_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_idx,
    input  wire logic [mcpi_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data,
    output mcpi_pkg::t_cfg                           o_cfg
);
    import mcpi_pkg::*;

    t_cfg r_cfg;

    // register writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.feedforward_gain   <= RST_FEEDFORWARD;
            r_cfg.proportional_gain  <= RST_PROPORTIONAL;
            r_cfg.integral_step_gain <= RST_INTEGRAL_STEP;
            r_cfg.integral_limit     <= RST_INTEGRAL_LIM;
            r_cfg.full_duty          <= RST_FULL_DUTY;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_FEEDFORWARD:   r_cfg.feedforward_gain   <= i_cfg_data[GAIN_WIDTH-1:0];
                CFG_PROPORTIONAL:  r_cfg.proportional_gain  <= i_cfg_data[GAIN_WIDTH-1:0];
                CFG_INTEGRAL_STEP: r_cfg.integral_step_gain <= i_cfg_data[GAIN_WIDTH-1:0];
                CFG_INTEGRAL_LIM:  r_cfg.integral_limit     <= i_cfg_data[DUTY_WIDTH-1:0];
                CFG_FULL_DUTY:     r_cfg.full_duty          <= i_cfg_data[DUTY_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* design/mcpi_mult_stage.sv */
// input register, deviation and the three gain products
`default_nettype none

module mcpi_mult_stage (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_load_in,
    input  wire logic                                     i_load_prod,
    input  wire logic                                     i_enable,
    input  wire logic                                     i_clear_integral,
    input  wire logic signed [mcpi_pkg::SAMPLE_WIDTH-1:0] i_target,
    input  wire logic signed [mcpi_pkg::SAMPLE_WIDTH-1:0] i_measured,
    input  wire mcpi_pkg::t_cfg                           i_cfg,
    output mcpi_pkg::t_prod_word                          o_prod
);
    import mcpi_pkg::*;

    logic                           r_enable;
    logic                           r_clear;
    logic signed [SAMPLE_WIDTH-1:0] r_target;
    logic signed [SAMPLE_WIDTH-1:0] r_measured;
    t_prod_word                     r_prod;

    logic signed [DEV_WIDTH-1:0] dev;
    t_prod                       dev_x;
    t_prod                       target_x;
    t_prod                       ki_x;
    t_prod                       kp_x;
    t_prod                       ff_x;
    t_prod_word                  n_prod;

    // sample register
    always_ff @(posedge i_clk) begin
        if (i_load_in) begin
            r_enable   <= i_enable;
            r_clear    <= i_clear_integral;
            r_target   <= i_target;
            r_measured <= i_measured;
        end
    end

    // deviation and products, operands widened so the products are exact
    always_comb begin
        dev      = DEV_WIDTH'(r_target) - DEV_WIDTH'(r_measured);
        dev_x    = PROD_WIDTH'(dev);
        target_x = PROD_WIDTH'(r_target);
        ki_x     = PROD_WIDTH'({1'b0, i_cfg.integral_step_gain});
        kp_x     = PROD_WIDTH'({1'b0, i_cfg.proportional_gain});
        ff_x     = PROD_WIDTH'({1'b0, i_cfg.feedforward_gain});

        n_prod.enable         = r_enable;
        n_prod.clear_integral = r_clear;
        n_prod.int_prod       = dev_x * ki_x;
        n_prod.kp_prod        = dev_x * kp_x;
        n_prod.ff_prod        = target_x * ff_x;
    end

    // product register
    always_ff @(posedge i_clk) begin
        if (i_load_prod) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

/* design/mcpi_integrator.sv */
// clamped integral state and feedforward plus proportional sum
`default_nettype none

module mcpi_integrator (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire mcpi_pkg::t_integ_ctl i_ctl,
    input  wire mcpi_pkg::t_prod_word i_prod,
    input  wire mcpi_pkg::t_cfg       i_cfg,
    output mcpi_pkg::t_acc            o_acc,
    output mcpi_pkg::t_sum            o_ffp,
    output logic                      o_enable
);
    import mcpi_pkg::*;

    t_acc r_acc;
    t_sum r_ffp;
    logic r_enable;

    t_acc base;
    t_sum acc_sum;
    t_sum ilim;
    t_acc n_acc;
    t_sum n_ffp;

    // integral step with clear and symmetric clamp
    always_comb begin
        base    = i_prod.clear_integral ? '0 : r_acc;
        acc_sum = SUM_WIDTH'(base) + SUM_WIDTH'(i_prod.int_prod);
        ilim    = SUM_WIDTH'({1'b0, i_cfg.integral_limit, {GAIN_FRACTION_BITS{1'b0}}});
        if (!i_prod.enable) begin
            n_acc = base;
        end else if (acc_sum > ilim) begin
            n_acc = ACC_WIDTH'(ilim);
        end else if (acc_sum < -ilim) begin
            n_acc = ACC_WIDTH'(-ilim);
        end else begin
            n_acc = ACC_WIDTH'(acc_sum);
        end
        n_ffp = SUM_WIDTH'(i_prod.ff_prod) + SUM_WIDTH'(i_prod.kp_prod);
    end

    // integral state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.update) begin
            r_acc <= n_acc;
        end
    end

    // open-loop sum travels with the request
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_ffp    <= n_ffp;
            r_enable <= i_prod.enable;
        end
    end

    assign o_acc    = r_acc;
    assign o_ffp    = r_ffp;
    assign o_enable = r_enable;

endmodule

`default_nettype wire

/* design/mcpi_drive_stage.sv */
// drive sum, saturation, truncation and bridge leg steering into the result register
`default_nettype none

module mcpi_drive_stage (
    input  wire logic                              i_clk,
    input  wire logic                              i_load,
    input  wire logic                              i_enable,
    input  wire mcpi_pkg::t_sum                    i_ffp,
    input  wire mcpi_pkg::t_acc                    i_acc,
    input  wire mcpi_pkg::t_cfg                    i_cfg,
    output logic [mcpi_pkg::DUTY_WIDTH-1:0]        o_duty_leg_a,
    output logic [mcpi_pkg::DUTY_WIDTH-1:0]        o_duty_leg_b,
    output logic                                   o_driver_on,
    output logic                                   o_saturated
);
    import mcpi_pkg::*;

    logic signed [DRIVE_WIDTH-1:0] drive;
    logic signed [DRIVE_WIDTH-1:0] drive_neg;
    logic signed [DRIVE_WIDTH-1:0] dlim;
    logic [DUTY_WIDTH-1:0]         n_leg_a;
    logic [DUTY_WIDTH-1:0]         n_leg_b;
    logic                          n_sat;

    logic [DUTY_WIDTH-1:0] r_leg_a;
    logic [DUTY_WIDTH-1:0] r_leg_b;
    logic                  r_driver_on;
    logic                  r_sat;

    // saturate beyond full duty, otherwise truncate magnitude toward zero
    always_comb begin
        drive     = DRIVE_WIDTH'(i_ffp) + DRIVE_WIDTH'(i_acc);
        drive_neg = -drive;
        dlim      = DRIVE_WIDTH'({1'b0, i_cfg.full_duty, {GAIN_FRACTION_BITS{1'b0}}});
        n_leg_a   = '0;
        n_leg_b   = '0;
        n_sat     = 1'b0;
        if (!i_enable) begin
            n_sat = 1'b0;
        end else if (drive > dlim) begin
            n_leg_b = i_cfg.full_duty;
            n_sat   = 1'b1;
        end else if (drive < -dlim) begin
            n_leg_a = i_cfg.full_duty;
            n_sat   = 1'b1;
        end else if (drive > 0) begin
            n_leg_b = drive[GAIN_FRACTION_BITS +: DUTY_WIDTH];
        end else if (drive < 0) begin
            n_leg_a = drive_neg[GAIN_FRACTION_BITS +: DUTY_WIDTH];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_leg_a     <= n_leg_a;
            r_leg_b     <= n_leg_b;
            r_driver_on <= i_enable;
            r_sat       <= n_sat;
        end
    end

    assign o_duty_leg_a = r_leg_a;
    assign o_duty_leg_b = r_leg_b;
    assign o_driver_on  = r_driver_on;
    assign o_saturated  = r_sat;

endmodule

`default_nettype wire

/* design/motor_current_pi_controller_unit.sv */
// Motor current PI controller: one current sample request in, one bridge drive request out.
// Each request passes four registers (sample, gain products, integral and open-loop sum,
// result) before its result is offered, and a new request is taken every cycle as long
// as the result side keeps up. Every stage holds its request independently, so a stalled
// result only blocks the stages behind it once they are full. The integral is updated in
// order, one request per cycle, when a request moves from the product register to the
// integral stage; only the clear and hold selects, an add and a clamp lie in that loop.
// Gains are unsigned Q8.16 in duty units; writes to the register port take effect at once
// and should be made while no request is in flight.
`default_nettype none

module motor_current_pi_controller_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [mcpi_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_idx,
    input  wire logic [mcpi_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data,
    mcpi_in_if.sink                                  i_in,
    mcpi_out_if.source                               o_out
);
    import mcpi_pkg::*;

    t_cfg       cfg;
    t_prod_word prod;
    t_integ_ctl integ_ctl;
    t_acc       acc;
    t_sum       ffp;
    logic       ffp_enable;

    logic r_v_in;
    logic r_v_prod;
    logic r_v_int;
    logic r_v_out;

    logic rdy_out;
    logic rdy_int;
    logic rdy_prod;
    logic rdy_in;

    // per-stage advance: a stage loads when it is empty or its content moves on
    always_comb begin
        rdy_out          = !r_v_out || o_out.ready;
        rdy_int          = !r_v_int || rdy_out;
        rdy_prod         = !r_v_prod || rdy_int;
        rdy_in           = !r_v_in || rdy_prod;
        integ_ctl.load   = rdy_int;
        integ_ctl.update = r_v_prod && rdy_int;
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_in   <= 1'b0;
            r_v_prod <= 1'b0;
            r_v_int  <= 1'b0;
            r_v_out  <= 1'b0;
        end else begin
            if (rdy_in) begin
                r_v_in <= i_in.valid;
            end
            if (rdy_prod) begin
                r_v_prod <= r_v_in;
            end
            if (rdy_int) begin
                r_v_int <= r_v_prod;
            end
            if (rdy_out) begin
                r_v_out <= r_v_int;
            end
        end
    end

    assign i_in.ready  = rdy_in;
    assign o_out.valid = r_v_out;

    mcpi_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    mcpi_mult_stage u_mult (
        .i_clk            (i_clk),
        .i_load_in        (rdy_in),
        .i_load_prod      (rdy_prod),
        .i_enable         (i_in.enable),
        .i_clear_integral (i_in.clear_integral),
        .i_target         (i_in.target_counts),
        .i_measured       (i_in.measured_counts),
        .i_cfg            (cfg),
        .o_prod           (prod)
    );

    mcpi_integrator u_integ (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (integ_ctl),
        .i_prod   (prod),
        .i_cfg    (cfg),
        .o_acc    (acc),
        .o_ffp    (ffp),
        .o_enable (ffp_enable)
    );

    mcpi_drive_stage u_drive (
        .i_clk        (i_clk),
        .i_load       (rdy_out),
        .i_enable     (ffp_enable),
        .i_ffp        (ffp),
        .i_acc        (acc),
        .i_cfg        (cfg),
        .o_duty_leg_a (o_out.duty_leg_a),
        .o_duty_leg_b (o_out.duty_leg_b),
        .o_driver_on  (o_out.driver_on),
        .o_saturated  (o_out.saturated)
    );

endmodule

`default_nettype wire

/* dv/tb_motor_current_pi_controller_unit.sv */
// self-checking testbench for the motor current pi controller unit
`timescale 1ns / 100ps

module tb_motor_current_pi_controller_unit;

    import mcpi_pkg::*;

    localparam int SMP_MAX        = (1 << (SAMPLE_WIDTH - 1)) - 1;
    localparam int SMP_MIN        = -(1 << (SAMPLE_WIDTH - 1));
    localparam int GAIN_MAX       = (1 << GAIN_WIDTH) - 1;
    localparam int DUTY_MAX       = (1 << DUTY_WIDTH) - 1;
    localparam int N_PHASES       = 9;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int HOLD_PHASE     = 3;
    localparam int HOLD_CYCLES    = 64;
    localparam int TAIL_CYCLES    = 8;
    localparam int STALL_LIMIT    = 1000;

    // first index past the register list
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_IDX_SPARE = CFG_IDX_WIDTH'(CFG_FULL_DUTY + 1);

    typedef struct packed {
        logic                           enable;
        logic                           clear_integral;
        logic signed [SAMPLE_WIDTH-1:0] target_counts;
        logic signed [SAMPLE_WIDTH-1:0] measured_counts;
    } t_sample;

    typedef struct packed {
        logic [DUTY_WIDTH-1:0] duty_leg_a;
        logic [DUTY_WIDTH-1:0] duty_leg_b;
        logic                  driver_on;
        logic                  saturated;
    } t_drive;

    typedef enum {ROW_SAMPLE, ROW_WRITE} t_row_kind;

    typedef struct {
        t_row_kind                 kind;
        logic [CFG_IDX_WIDTH-1:0]  idx;
        logic [CFG_DATA_WIDTH-1:0] data;
        t_sample                   smp;
        bit                        typed;
        t_drive                    want;
    } t_row;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_wr_en;
    logic [CFG_IDX_WIDTH-1:0]  cfg_idx;
    logic [CFG_DATA_WIDTH-1:0] cfg_data;

    mcpi_in_if  in_ch ();
    mcpi_out_if out_ch ();

    motor_current_pi_controller_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // shadow of the controller: live registers and integral in q.16 duty units
    t_cfg    cfg_model;
    longint  duty_integral;
    t_drive  expected_drives[$];
    t_row    directed_rows[$];
    int      mismatch_count = 0;
    int      phase_bias = 0;
    int      send_calm = 0;
    int      sink_calm = 0;
    bit      hold_result_req = 1'b0;
    int      idle_cycles = 0;

    // 12 ns clock
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // pi step with feedforward, clamped integral and bridge leg split
    function automatic t_drive predict_drive(input t_sample s);
        t_drive r;
        longint tgt, dev, ilim, dlim, drive;
        r    = '0;
        tgt  = longint'($signed(s.target_counts));
        dev  = tgt - longint'($signed(s.measured_counts));
        ilim = longint'(cfg_model.integral_limit) <<< GAIN_FRACTION_BITS;
        dlim = longint'(cfg_model.full_duty) <<< GAIN_FRACTION_BITS;
        if (s.clear_integral)
            duty_integral = 0;
        // disabled: integral held, bridge off
        if (!s.enable)
            return r;
        duty_integral += dev * longint'(cfg_model.integral_step_gain);
        if (duty_integral > ilim)
            duty_integral = ilim;
        else if (duty_integral < -ilim)
            duty_integral = -ilim;
        drive = tgt * longint'(cfg_model.feedforward_gain)
              + dev * longint'(cfg_model.proportional_gain)
              + duty_integral;
        r.driver_on = 1'b1;
        if (drive > dlim) begin
            r.duty_leg_b = cfg_model.full_duty;
            r.saturated  = 1'b1;
        end else if (drive < -dlim) begin
            r.duty_leg_a = cfg_model.full_duty;
            r.saturated  = 1'b1;
        end else if (drive > 0) begin
            r.duty_leg_b = DUTY_WIDTH'(drive >>> GAIN_FRACTION_BITS);
        end else if (drive < 0) begin
            r.duty_leg_a = DUTY_WIDTH'((-drive) >>> GAIN_FRACTION_BITS);
        end
        return r;
    endfunction

    // idle cycles before the next request, with calm stretches of none
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 3);
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] clamp_sample(input int v);
        if (v > SMP_MAX)
            v = SMP_MAX;
        else if (v < SMP_MIN)
            v = SMP_MIN;
        return SAMPLE_WIDTH'(v);
    endfunction

    function automatic int corner_value();
        case ($urandom_range(0, 4))
            0: return SMP_MIN;
            1: return -1;
            2: return 0;
            3: return 1;
            default: return SMP_MAX;
        endcase
    endfunction

    // mostly a loop tracking its target with a per-phase offset, some noise and corners
    function automatic t_sample draw_sample();
        t_sample s;
        int t, m, pick;
        pick             = $urandom_range(0, 19);
        s.enable         = ($urandom_range(0, 9) != 0);
        s.clear_integral = ($urandom_range(0, 24) == 0);
        t = int'($urandom_range(0, 2 * SMP_MAX + 1)) + SMP_MIN;
        if (pick < 12) begin
            m = t - phase_bias + int'($urandom_range(0, 400)) - 200;
        end else if (pick < 16) begin
            m = int'($urandom_range(0, 2 * SMP_MAX + 1)) + SMP_MIN;
        end else if (pick < 19) begin
            t = corner_value();
            m = corner_value();
        end else begin
            m = t;
        end
        s.target_counts   = clamp_sample(t);
        s.measured_counts = clamp_sample(m);
        return s;
    endfunction

    // register value for a phase: extremes first, then defaults, then random
    function automatic int unsigned pick_setting(input int p, input int unsigned rst,
                                                 input int unsigned max_val);
        int unsigned v;
        if (p == 0)
            return max_val;
        if (p == 1)
            return 0;
        if (p == 2)
            return rst;
        case ($urandom_range(0, 7))
            0: v = 0;
            1: v = max_val;
            2, 3: v = rst;
            4, 5: v = $urandom_range(0, 2 * rst);
            default: v = $urandom_range(0, max_val);
        endcase
        if (v > max_val)
            v = max_val;
        return v;
    endfunction

    // 14 bit register data with junk in the unused upper bits
    function automatic logic [CFG_DATA_WIDTH-1:0] pad_duty(input int unsigned v);
        logic [CFG_DATA_WIDTH-1:0] d;
        d                 = CFG_DATA_WIDTH'($urandom);
        d[DUTY_WIDTH-1:0] = DUTY_WIDTH'(v);
        return d;
    endfunction

    task automatic add_write(input logic [CFG_IDX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] data);
        t_row r;
        r       = '{kind: ROW_WRITE, default: '0};
        r.idx   = idx;
        r.data  = data;
        directed_rows.push_back(r);
    endtask

    task automatic add_sample(input bit en, input bit clr, input int tgt, input int meas);
        t_row r;
        r       = '{kind: ROW_SAMPLE, default: '0};
        r.smp   = '{en, clr, clamp_sample(tgt), clamp_sample(meas)};
        directed_rows.push_back(r);
    endtask

    task automatic add_typed(input bit en, input bit clr, input int tgt, input int meas,
                             input int unsigned leg_a, input int unsigned leg_b,
                             input bit on, input bit sat);
        add_sample(en, clr, tgt, meas);
        directed_rows[$].typed = 1'b1;
        directed_rows[$].want  = '{DUTY_WIDTH'(leg_a), DUTY_WIDTH'(leg_b), on, sat};
    endtask

    // register write, shadow follows at the same edge
    task automatic cfg_write(input logic [CFG_IDX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_idx   <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_FEEDFORWARD:   cfg_model.feedforward_gain   = data[GAIN_WIDTH-1:0];
            CFG_PROPORTIONAL:  cfg_model.proportional_gain  = data[GAIN_WIDTH-1:0];
            CFG_INTEGRAL_STEP: cfg_model.integral_step_gain = data[GAIN_WIDTH-1:0];
            CFG_INTEGRAL_LIM:  cfg_model.integral_limit     = data[DUTY_WIDTH-1:0];
            CFG_FULL_DUTY:     cfg_model.full_duty          = data[DUTY_WIDTH-1:0];
            default: ;
        endcase
    endtask

    // offer one sample request and queue its expected drive once taken
    task automatic send_sample(input t_sample s, input bit typed, input t_drive typed_drive);
        int     gap;
        t_drive want;
        gap = draw_wait(send_calm);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.enable          <= s.enable;
        in_ch.clear_integral  <= s.clear_integral;
        in_ch.target_counts   <= s.target_counts;
        in_ch.measured_counts <= s.measured_counts;
        do @(posedge clk); while (!in_ch.ready);
        want = predict_drive(s);
        if (typed)
            want = typed_drive;
        expected_drives.push_back(want);
    endtask

    // stop offering and let every pending result come back
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (expected_drives.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // result side: random stalls, one long hold-off, compare against oldest expectation
    initial begin
        int     stall;
        t_drive got, want;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            stall = draw_wait(sink_calm);
            if (hold_result_req) begin
                hold_result_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            got = '{out_ch.duty_leg_a, out_ch.duty_leg_b, out_ch.driver_on, out_ch.saturated};
            if (expected_drives.size() == 0) begin
                $display("%0t: result with no request pending, actual a=%0d b=%0d on=%0b sat=%0b",
                         $time, got.duty_leg_a, got.duty_leg_b, got.driver_on, got.saturated);
                mismatch_count++;
            end else begin
                want = expected_drives.pop_front();
                check_field("duty_leg_a", want.duty_leg_a, got.duty_leg_a);
                check_field("duty_leg_b", want.duty_leg_b, got.duty_leg_b);
                check_field("driver_on", want.driver_on, got.driver_on);
                check_field("saturated", want.saturated, got.saturated);
            end
        end
    end

    // watchdog on cycles without any progress
    always @(posedge clk) begin
        if (!rst_n || cfg_wr_en || (in_ch.valid && in_ch.ready)
                || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // main sequence
    initial begin
        bit writing;
        rst_n                 <= 1'b0;
        cfg_wr_en             <= 1'b0;
        cfg_idx               <= '0;
        cfg_data              <= '0;
        in_ch.valid           <= 1'b0;
        in_ch.enable          <= 1'b0;
        in_ch.clear_integral  <= 1'b0;
        in_ch.target_counts   <= '0;
        in_ch.measured_counts <= '0;
        cfg_model = '{RST_FEEDFORWARD, RST_PROPORTIONAL, RST_INTEGRAL_STEP,
                      RST_INTEGRAL_LIM, RST_FULL_DUTY};
        duty_integral = 0;

        // directed rows: defaults, extremes, clamps, exact limit, zero limits, spare index
        add_typed(0, 0, SMP_MAX, SMP_MIN, 0, 0, 0, 0);
        add_typed(1, 1, 0, 0, 0, 0, 1, 0);
        add_typed(1, 1, SMP_MAX, SMP_MAX, 0, RST_FULL_DUTY, 1, 1);
        add_typed(1, 1, SMP_MIN, SMP_MIN, RST_FULL_DUTY, 0, 1, 1);
        add_sample(1, 0, SMP_MAX, SMP_MIN);
        add_sample(1, 0, SMP_MIN, SMP_MAX);
        add_typed(0, 1, 100, -100, 0, 0, 0, 0);
        add_sample(1, 0, 1, 0);
        add_write(CFG_INTEGRAL_STEP, '1);
        add_sample(1, 1, SMP_MAX, SMP_MIN);
        add_sample(1, 0, SMP_MAX, SMP_MIN);
        add_sample(1, 0, SMP_MIN, SMP_MAX);
        add_write(CFG_FEEDFORWARD, '0);
        add_write(CFG_PROPORTIONAL, '0);
        add_sample(1, 0, 0, 0);
        add_write(CFG_INTEGRAL_LIM, CFG_DATA_WIDTH'(RST_FULL_DUTY));
        add_typed(1, 0, SMP_MAX, SMP_MIN, 0, RST_FULL_DUTY, 1, 0);
        add_write(CFG_FULL_DUTY, '0);
        add_sample(1, 0, 5, 3);
        add_write(CFG_INTEGRAL_LIM, '0);
        add_typed(1, 0, -7, 9, 0, 0, 1, 0);
        add_write(CFG_IDX_SPARE, '1);
        add_typed(1, 0, -7, 9, 0, 0, 1, 0);
        add_write(CFG_FEEDFORWARD, RST_FEEDFORWARD);
        add_write(CFG_PROPORTIONAL, RST_PROPORTIONAL);
        add_write(CFG_INTEGRAL_LIM, '1);
        add_write(CFG_FULL_DUTY, '1);
        add_typed(1, 1, SMP_MAX, SMP_MAX, 0, DUTY_MAX, 1, 1);
        add_typed(1, 1, SMP_MIN, SMP_MIN, DUTY_MAX, 0, 1, 1);
        add_sample(1, 0, 10, 12);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // walk the directed rows, writes only once the pipe is empty
        writing = 1'b0;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE) begin
                if (!writing)
                    wait_idle();
                writing = 1'b1;
                cfg_write(directed_rows[i].idx, directed_rows[i].data);
            end else begin
                if (writing)
                    cfg_wr_en <= 1'b0;
                writing = 1'b0;
                send_sample(directed_rows[i].smp, directed_rows[i].typed,
                            directed_rows[i].want);
            end
        end

        // random phases, each with its own register setting and tracking offset
        for (int p = 0; p < N_PHASES; p++) begin
            wait_idle();
            cfg_write(CFG_FEEDFORWARD,
                      CFG_DATA_WIDTH'(pick_setting(p, RST_FEEDFORWARD, GAIN_MAX)));
            cfg_write(CFG_PROPORTIONAL,
                      CFG_DATA_WIDTH'(pick_setting(p, RST_PROPORTIONAL, GAIN_MAX)));
            cfg_write(CFG_INTEGRAL_STEP,
                      CFG_DATA_WIDTH'(pick_setting(p, RST_INTEGRAL_STEP, GAIN_MAX)));
            cfg_write(CFG_INTEGRAL_LIM, pad_duty(pick_setting(p, RST_INTEGRAL_LIM, DUTY_MAX)));
            cfg_write(CFG_FULL_DUTY, pad_duty(pick_setting(p, RST_FULL_DUTY, DUTY_MAX)));
            // writes past the register list must not land anywhere
            if ($urandom_range(0, 1) == 0)
                cfg_write(CFG_IDX_WIDTH'($urandom_range(CFG_IDX_SPARE, (1 << CFG_IDX_WIDTH) - 1)),
                          CFG_DATA_WIDTH'($urandom));
            cfg_wr_en <= 1'b0;
            phase_bias = int'($urandom_range(0, 600)) - 300;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // hold results back while requests keep coming, to back up the pipe
                if (p == HOLD_PHASE && k == ITEMS_PER_PHASE / 2)
                    hold_result_req = 1'b1;
                send_sample(draw_sample(), 1'b0, '0);
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
design/mcpi_pkg.sv
design/mcpi_in_if.sv
design/mcpi_out_if.sv
design/mcpi_cfg_regs.sv
design/mcpi_mult_stage.sv
design/mcpi_integrator.sv
design/mcpi_drive_stage.sv
design/motor_current_pi_controller_unit.sv
dv/tb_motor_current_pi_controller_unit.sv
